// ===== rtl/hmrs_pkg.sv =====
// Shared types and constants for the hexagonal Mehrstellen right-hand-side stencil.
// Holds sample and tap types, register codes and the Q0.24 coefficients.
// Has no dependencies.
package hmrs_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int COEF_W    = 24;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd62;

  localparam logic [COEF_W-1:0] COEF_C = 24'd9786709;
  localparam logic [COEF_W-1:0] COEF_Z = 24'd1398101;
  localparam logic [COEF_W-1:0] COEF_F = 24'd699051;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t       centre;
    sample_t       z_near;
    sample_t       z_far;
    sample_t [5:0] hex;
  } taps_t;

  typedef struct packed {
    logic advance;
    logic restart;
  } dly_ctrl_t;

endpackage

// ===== rtl/hmrs_cfg_if.sv =====
// Configuration write channel: register index and write data with valid and ready.
// Depends on hmrs_pkg.
interface hmrs_cfg_if import hmrs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hmrs_in_if.sv =====
// Input sample channel: one padded grid sample per transfer.
// Depends on hmrs_pkg.
interface hmrs_in_if import hmrs_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    grid_start;

  modport source (output valid, output sample, output grid_start, input ready);
  modport sink (input valid, input sample, input grid_start, output ready);
endinterface

// ===== rtl/hmrs_out_if.sv =====
// Result channel: one stencil value per transfer with saturation and end-of-grid flags.
// Depends on hmrs_pkg.
interface hmrs_out_if import hmrs_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t result;
  logic    saturated;
  logic    last_of_grid;

  modport source (output valid, output result, output saturated, output last_of_grid,
                  input ready);
  modport sink (input valid, input result, input saturated, input last_of_grid,
                output ready);
endinterface

// ===== rtl/hmrs_delay.sv =====
// Variable-length delay line built on a circular single-port-write memory.
// The read address runs one transfer ahead so the delayed word is ready on accept.
// Depends on hmrs_pkg.
module hmrs_delay import hmrs_pkg::*; #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  dly_ctrl_t        ctrl,
  input  logic [AW-1:0]    len_m1,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    ptr;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    ptr_next;
  logic [AW-1:0]    rd_addr;

  always_comb begin
    wr_addr  = ctrl.restart ? '0 : ptr;
    ptr_next = (wr_addr >= len_m1) ? '0 : wr_addr + 1'b1;
    rd_addr  = ctrl.advance ? ptr_next : ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctrl.advance) begin
      ptr <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/hmrs_mac.sv =====
// Weighted sum, rounding and saturation pipeline with the output register.
// Three stages: tap pre-sums, coefficient products, sum with round and clamp.
// Depends on hmrs_pkg and hmrs_out_if.
module hmrs_mac import hmrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_last,
  input  taps_t      taps,
  output logic       advance,
  hmrs_out_if.source outp
);

  localparam int ZSUM_W = SAMPLE_W + 1;
  localparam int FSUM_W = SAMPLE_W + 3;
  localparam int PC_W   = SAMPLE_W + COEF_W + 1;
  localparam int PZ_W   = ZSUM_W + COEF_W + 1;
  localparam int PF_W   = FSUM_W + COEF_W + 1;
  localparam int ACC_W  = PF_W + 2;
  localparam int RND_W  = ACC_W - COEF_W;
  localparam logic signed [ACC_W-1:0] RND_BIAS =
    {{(ACC_W-COEF_W){1'b0}}, 1'b1, {(COEF_W-1){1'b0}}};

  logic                     s1_valid, s1_last;
  sample_t                  s1_c;
  logic signed [ZSUM_W-1:0] s1_zsum;
  logic signed [FSUM_W-1:0] s1_fsum;
  logic signed [ZSUM_W-1:0] zsum;
  logic signed [FSUM_W-1:0] fsum;

  logic                     s2_valid, s2_last;
  logic signed [PC_W-1:0]   s2_pc;
  logic signed [PZ_W-1:0]   s2_pz;
  logic signed [PF_W-1:0]   s2_pf;

  logic signed [ACC_W-1:0]  acc;
  logic signed [RND_W-1:0]  rounded;
  logic [RND_W-SAMPLE_W:0]  high_bits;
  logic                     fits;
  sample_t                  clamped;

  logic    out_valid, out_sat, out_last;
  sample_t out_result;

  assign advance = !out_valid || outp.ready;

  always_comb begin
    zsum = ZSUM_W'($signed(taps.z_near)) + ZSUM_W'($signed(taps.z_far));
    fsum = '0;
    for (int i = 0; i < 6; i++) begin
      fsum = fsum + FSUM_W'($signed(taps.hex[i]));
    end
  end

  always_comb begin
    acc = ACC_W'(s2_pc) + ACC_W'(s2_pz) + ACC_W'(s2_pf) + RND_BIAS;
    rounded   = acc[ACC_W-1:COEF_W];
    high_bits = rounded[RND_W-1:SAMPLE_W-1];
    fits      = (&high_bits) || !(|high_bits);
    if (fits) begin
      clamped = rounded[SAMPLE_W-1:0];
    end else if (rounded[RND_W-1]) begin
      clamped = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      clamped = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= item_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last    <= item_last;
      s1_c       <= taps.centre;
      s1_zsum    <= zsum;
      s1_fsum    <= fsum;
      s2_last    <= s1_last;
      s2_pc      <= s1_c * $signed({1'b0, COEF_C});
      s2_pz      <= s1_zsum * $signed({1'b0, COEF_Z});
      s2_pf      <= s1_fsum * $signed({1'b0, COEF_F});
      out_last   <= s2_last;
      out_result <= clamped;
      out_sat    <= !fits;
    end
  end

  assign outp.valid        = out_valid;
  assign outp.result       = out_result;
  assign outp.saturated    = out_sat;
  assign outp.last_of_grid = out_last;

endmodule

// ===== rtl/hex_mehrstellen_rhs_stencil.sv =====
// Top level of the hexagonal Mehrstellen right-hand-side stencil over a streamed 3D grid.
// Holds size registers, raster position, tap delay memories and the tap registers.
// Depends on hmrs_pkg, the channel interfaces, hmrs_delay and hmrs_mac.
//
//   Channel  Direction  Payload                               Transfer when
//   cfg      in         index, data (size_x/size_y/size_z)    valid && ready
//   inp      in         sample, grid_start                    valid && ready
//   outp     out        result, saturated, last_of_grid       valid && ready
//
// One sample is taken every cycle unless a result waits; results pass the s1, s2 and
// output registers. Taps come from the input sample, row- and plane-delay memories,
// each written and read once per transfer, and four tap registers.
// Input ready follows the output register: the pipeline halts only while a result waits.
// Reset clears control state only; the delay memories need no clearing pass.
module hex_mehrstellen_rhs_stencil import hmrs_pkg::*; #(
  parameter int MAX_X = 62,
  parameter int MAX_Y = 62,
  parameter int MAX_Z = 62
) (
  input  logic       clk,
  input  logic       rst,
  hmrs_cfg_if.sink   cfg,
  hmrs_in_if.sink    inp,
  hmrs_out_if.source outp
);

  localparam int PXW     = $clog2(MAX_X + 2);
  localparam int PYW     = $clog2(MAX_Y + 2);
  localparam int PZW     = $clog2(MAX_Z + 2);
  localparam int RW      = $clog2(MAX_Z + 3);
  localparam int PROD_W  = PYW + RW;
  localparam int R_DEPTH = MAX_Z + 2;
  localparam int Q_DEPTH = MAX_Y * (MAX_Z + 2) - 1;
  localparam int R_AW    = $clog2(R_DEPTH);
  localparam int Q_AW    = $clog2(Q_DEPTH);

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [PXW-1:0]    sx, pos_x, px0, pos_x_next;
  logic [PYW-1:0]    sy, pos_y, py0, pos_y_next;
  logic [PZW-1:0]    sz, pos_z, pz0, pos_z_next;
  logic [RW-1:0]     row;
  logic [PROD_W-1:0] plane_rows;
  logic [R_AW-1:0]   r_len_m1;
  logic [Q_AW-1:0]   q_len_m1;

  logic        advance, accept, interior, last_pt;
  dly_ctrl_t   dly_ctrl;
  logic [4*SAMPLE_W-1:0] r_wr, r_rd;
  logic [2*SAMPLE_W-1:0] q_wr, q_rd;
  sample_t     f0, f1, f2, f3, g0, g1;
  sample_t     reg_q0, reg_q1, reg_a, reg_b;
  taps_t       taps;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SIZE_X: size_x <= cfg.data;
        REG_SIZE_Y: size_y <= cfg.data;
        REG_SIZE_Z: size_z <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_x == '0) begin
      sx = PXW'(1);
    end else if (int'(size_x) > MAX_X) begin
      sx = PXW'(MAX_X);
    end else begin
      sx = PXW'(size_x);
    end
    if (size_y == '0) begin
      sy = PYW'(1);
    end else if (int'(size_y) > MAX_Y) begin
      sy = PYW'(MAX_Y);
    end else begin
      sy = PYW'(size_y);
    end
    if (size_z == '0) begin
      sz = PZW'(1);
    end else if (int'(size_z) > MAX_Z) begin
      sz = PZW'(MAX_Z);
    end else begin
      sz = PZW'(size_z);
    end
  end

  always_comb begin
    row        = RW'(sz) + RW'(2);
    plane_rows = PROD_W'(sy) * PROD_W'(row);
    r_len_m1   = R_AW'(sz) + R_AW'(1);
    q_len_m1   = Q_AW'(plane_rows - PROD_W'(2));
  end

  // Raster position of the incoming sample.
  assign accept    = inp.valid && advance;
  assign inp.ready = advance;

  always_comb begin
    px0 = inp.grid_start ? '0 : pos_x;
    py0 = inp.grid_start ? '0 : pos_y;
    pz0 = inp.grid_start ? '0 : pos_z;

    interior = (px0 >= PXW'(2)) && (px0 <= sx + 1'b1) &&
               (py0 >= PYW'(1)) && (py0 <= sy) &&
               (pz0 >= PZW'(1)) && (pz0 <= sz);
    last_pt  = (px0 == sx + 1'b1) && (py0 == sy) && (pz0 == sz);

    pos_x_next = px0;
    pos_y_next = py0;
    if (pz0 >= sz + 1'b1) begin
      pos_z_next = '0;
      if (py0 >= sy + 1'b1) begin
        pos_y_next = '0;
        pos_x_next = (px0 >= sx + 1'b1) ? '0 : px0 + 1'b1;
      end else begin
        pos_y_next = py0 + 1'b1;
      end
    end else begin
      pos_z_next = pz0 + 1'b1;
    end
    if (pos_y_next > sy + 1'b1) begin
      pos_y_next = '0;
    end
    if (pos_x_next > sx + 1'b1) begin
      pos_x_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  // Tap delay network. The row memory delays by one padded row, the plane memory
  // by one padded plane less two rows and one sample.
  always_comb begin
    dly_ctrl.advance = accept;
    dly_ctrl.restart = inp.grid_start;
  end

  assign f0 = r_rd[SAMPLE_W-1:0];
  assign f1 = r_rd[2*SAMPLE_W-1:SAMPLE_W];
  assign f2 = r_rd[3*SAMPLE_W-1:2*SAMPLE_W];
  assign f3 = r_rd[4*SAMPLE_W-1:3*SAMPLE_W];
  assign g0 = q_rd[SAMPLE_W-1:0];
  assign g1 = q_rd[2*SAMPLE_W-1:SAMPLE_W];

  assign r_wr = {reg_q1, reg_a, g0, inp.sample};
  assign q_wr = {f2, f0};

  hmrs_delay #(
    .WIDTH (4 * SAMPLE_W),
    .DEPTH (R_DEPTH)
  ) u_row_delay (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (dly_ctrl),
    .len_m1  (r_len_m1),
    .wr_data (r_wr),
    .rd_data (r_rd)
  );

  hmrs_delay #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (Q_DEPTH)
  ) u_plane_delay (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (dly_ctrl),
    .len_m1  (q_len_m1),
    .wr_data (q_wr),
    .rd_data (q_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      reg_q0 <= g0;
      reg_q1 <= g1;
      reg_a  <= f1;
      reg_b  <= reg_a;
    end
  end

  always_comb begin
    taps.centre = reg_a;
    taps.z_near = f1;
    taps.z_far  = reg_b;
    taps.hex[0] = inp.sample;
    taps.hex[1] = f0;
    taps.hex[2] = f2;
    taps.hex[3] = f3;
    taps.hex[4] = reg_q1;
    taps.hex[5] = reg_q0;
  end

  hmrs_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .item_valid (accept && interior),
    .item_last  (last_pt),
    .taps       (taps),
    .advance    (advance),
    .outp       (outp)
  );

endmodule

// ===== tb/sv/hmrs_tb_pkg.sv =====
// Scoreboard package for the hexagonal Mehrstellen stencil testbench.
// Predicts every stencil point from its own delay line of padded samples and checks results.
// Depends on hmrs_pkg.
package hmrs_tb_pkg;
  import hmrs_pkg::*;

  localparam int GRID_MAX_X  = 62;
  localparam int GRID_MAX_Y  = 62;
  localparam int GRID_MAX_Z  = 62;
  localparam int DELAY_DEPTH = 2 * (GRID_MAX_Y + 2) * (GRID_MAX_Z + 2) + (GRID_MAX_Z + 2);
  localparam int MAX_REPORTS = 40;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam sample_t SAMPLE_MIN = 32'sh8000_0000;

  typedef enum int unsigned {FILL_RANDOM, FILL_EXTREME, FILL_FLAT, FILL_SMALL} fill_t;

  typedef struct packed {
    sample_t result;
    logic    saturated;
    logic    last_of_grid;
  } point_t;

  class stencil_scoreboard;
    int unsigned pad_x, pad_y, pad_z;
    int unsigned points_seen, saturations, grids_done, errors;
    point_t pending_points[$];
    local logic [SIZE_W-1:0] size_reg[3];
    local sample_t history[DELAY_DEPTH];
    local int unsigned wr_ptr, at_x, at_y, at_z;

    function new();
      foreach (size_reg[i]) size_reg[i] = SIZE_RESET;
      foreach (history[i]) history[i] = '0;
      wr_ptr = 0;
      at_x = 0;
      at_y = 0;
      at_z = 0;
      points_seen = 0;
      saturations = 0;
      grids_done = 0;
      errors = 0;
      update_extents();
    endfunction

    local function int unsigned padded(logic [SIZE_W-1:0] value, int unsigned top);
      if (value == 0) return 3;
      if (value > top) return top + 2;
      return value + 2;
    endfunction

    local function void update_extents();
      pad_x = padded(size_reg[REG_SIZE_X], GRID_MAX_X);
      pad_y = padded(size_reg[REG_SIZE_Y], GRID_MAX_Y);
      pad_z = padded(size_reg[REG_SIZE_Z], GRID_MAX_Z);
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] which, logic [SIZE_W-1:0] value);
      case (which) inside
        REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: begin
          size_reg[which] = value;
          update_extents();
        end
        default: ;
      endcase
    endfunction

    local function longint tap(int unsigned back);
      return longint'(history[(wr_ptr + DELAY_DEPTH - back) % DELAY_DEPTH]);
    endfunction

    // The point centred one plane back is complete once the sample at x+1 arrives.
    function void take_sample(sample_t value, logic start);
      int unsigned row, plane;
      longint acc, rounded;
      point_t p;
      row = pad_z;
      plane = pad_y * pad_z;
      if (start) begin
        at_x = 0;
        at_y = 0;
        at_z = 0;
      end
      history[wr_ptr] = value;
      if (at_x >= 2 && at_x <= pad_x - 1 && at_y >= 1 && at_y <= pad_y - 2 &&
          at_z >= 1 && at_z <= pad_z - 2) begin
        acc = longint'(COEF_C) * tap(plane)
            + longint'(COEF_Z) * (tap(plane + 1) + tap(plane - 1))
            + longint'(COEF_F) * (tap(0) + tap(row) + tap(plane + row) + tap(2 * plane)
                                  + tap(2 * plane - row) + tap(plane - row));
        rounded = (acc + (longint'(1) <<< 23)) >>> 24;
        p.saturated = 1'b0;
        if (rounded > longint'(SAMPLE_MAX)) begin
          rounded = SAMPLE_MAX;
          p.saturated = 1'b1;
        end else if (rounded < longint'(SAMPLE_MIN)) begin
          rounded = SAMPLE_MIN;
          p.saturated = 1'b1;
        end
        p.result = rounded[SAMPLE_W-1:0];
        p.last_of_grid = (at_x == pad_x - 1 && at_y == pad_y - 2 && at_z == pad_z - 2);
        pending_points.push_back(p);
      end
      wr_ptr = (wr_ptr + 1) % DELAY_DEPTH;
      at_z++;
      if (at_z >= pad_z) begin
        at_z = 0;
        at_y++;
        if (at_y >= pad_y) begin
          at_y = 0;
          at_x++;
          if (at_x >= pad_x) at_x = 0;
        end
      end
      if (at_y >= pad_y) at_y = 0;
      if (at_x >= pad_x) at_x = 0;
    endfunction

    local function void flag(string field, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(sample_t result, logic saturated, logic last_of_grid);
      point_t want;
      if (pending_points.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result transfer with none expected, expected nothing, got %0d",
                   $time, result);
        return;
      end
      want = pending_points.pop_front();
      points_seen++;
      if (want.saturated) saturations++;
      if (want.last_of_grid) grids_done++;
      if (result !== want.result) flag("result", want.result, result);
      if (saturated !== want.saturated) flag("saturated", want.saturated, saturated);
      if (last_of_grid !== want.last_of_grid)
        flag("last_of_grid", want.last_of_grid, last_of_grid);
    endfunction
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench for hex_mehrstellen_rhs_stencil: streams padded grids of several sizes
// with random handshake gaps and checks every result against the scoreboard's prediction.
// Depends on hmrs_pkg, hmrs_tb_pkg, the channel interfaces and the stencil RTL.
module testbench import hmrs_pkg::*, hmrs_tb_pkg::*;;

  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 420;

  logic clk;
  logic rst;

  hmrs_cfg_if cfg ();
  hmrs_in_if  inp ();
  hmrs_out_if outp ();

  hex_mehrstellen_rhs_stencil #(
    .MAX_X(GRID_MAX_X),
    .MAX_Y(GRID_MAX_Y),
    .MAX_Z(GRID_MAX_Z)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .inp (inp),
    .outp(outp)
  );

  stencil_scoreboard board;
  bit sender_rush;
  bit sink_rush;
  bit hold_done;
  int unsigned samples_sent;
  int unsigned settings_used;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic put_sample(input sample_t value, input logic start);
    int unsigned pause;
    pause = sender_rush ? 0 : $urandom_range(0, 6);
    if (pause > 0) begin
      inp.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    inp.valid <= 1'b1;
    inp.sample <= value;
    inp.grid_start <= start;
    do @(posedge clk); while (inp.ready !== 1'b1);
    board.take_sample(value, start);
    samples_sent++;
  endtask

  task automatic put_grid(input fill_t style, input sample_t flat, input bit fresh,
                          input int unsigned cut);
    int unsigned total;
    sample_t value;
    total = board.pad_x * board.pad_y * board.pad_z;
    sender_rush = ($urandom_range(0, 3) == 0);
    for (int unsigned n = 0; n < total; n++) begin
      if (cut != 0 && n == cut) break;
      case (style)
        FILL_RANDOM: value = $urandom;
        FILL_EXTREME: begin
          case ($urandom_range(0, 4))
            0: value = SAMPLE_MAX;
            1: value = SAMPLE_MIN;
            2: value = '0;
            3: value = '1;
            default: value = 1;
          endcase
        end
        FILL_FLAT: value = flat;
        default: value = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      endcase
      put_sample(value, fresh && n == 0);
    end
  endtask

  // Waits until every predicted point has come out, then lets the pipeline empty.
  task automatic drain();
    inp.valid <= 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_sizes(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                            input logic [SIZE_W-1:0] sz, input bit with_unused);
    logic [CFG_IDX_W-1:0] which[4];
    logic [SIZE_W-1:0] value[4];
    which = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_UNUSED};
    value = '{sx, sy, sz, 6'h2A};
    for (int i = 0; i < (with_unused ? 4 : 3); i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= which[i];
      cfg.data <= value[i];
      do @(posedge clk); while (cfg.ready !== 1'b1);
      board.write_size(which[i], value[i]);
    end
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : result_sink
    int unsigned pause;
    outp.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      pause = sink_rush ? 0 : $urandom_range(0, 6);
      if (!hold_done && board.points_seen == HOLD_AFTER) begin
        hold_done = 1'b1;
        pause = HOLD_CYCLES;
      end
      if (pause > 0) begin
        outp.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      outp.ready <= 1'b1;
      do @(posedge clk); while (outp.valid !== 1'b1);
      board.check_result(outp.result, outp.saturated, outp.last_of_grid);
      if ($urandom_range(0, 31) == 0) sink_rush = ~sink_rush;
    end
  end

  initial begin : stimulus
    int unsigned base, grids, total, cut;
    bit broken;
    board = new();
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = REG_SIZE_X;
    cfg.data = '0;
    inp.valid = 1'b0;
    inp.sample = '0;
    inp.grid_start = 1'b0;
    sender_rush = 1'b0;
    sink_rush = 1'b0;
    hold_done = 1'b0;
    samples_sent = 0;
    settings_used = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Smallest grid with every tap at the negative limit, plus a write to the unused index.
    load_sizes(6'd1, 6'd1, 6'd1, 1'b1);
    put_grid(FILL_FLAT, SAMPLE_MIN, 1'b1, 0);
    drain();

    // A size of zero behaves as one; the second grid follows without a start marker.
    load_sizes(6'd0, 6'd0, 6'd0, 1'b0);
    put_grid(FILL_EXTREME, '0, 1'b1, 0);
    put_grid(FILL_RANDOM, '0, 1'b0, 0);
    drain();

    base = samples_sent;
    while (samples_sent - base < RANDOM_ITEMS) begin
      load_sizes(SIZE_W'($urandom_range(0, 4)), SIZE_W'($urandom_range(0, 4)),
                 SIZE_W'($urandom_range(0, 4)), 1'b0);
      grids = $urandom_range(1, 3);
      broken = 1'b0;
      for (int unsigned g = 0; g < grids; g++) begin
        total = board.pad_x * board.pad_y * board.pad_z;
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : 0;
        put_grid(fill_t'($urandom_range(0, 3)), $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN,
                 g == 0 || broken || $urandom_range(0, 2) == 0, cut);
        broken = (cut != 0);
      end
      drain();
    end

    $display("Streamed %0d samples over %0d size settings; %0d stencil points checked,",
             samples_sent, settings_used, board.points_seen);
    $display("%0d of them saturated, %0d grids run to their last point.",
             board.saturations, board.grids_done);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
